>>> sv/mmn_pkg.sv
// shared types, constants and helpers for the matrix multiply block
package mmn_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = 4;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
  localparam int FRAC_W  = 16;
  localparam int TRUNC_W = ACC_W - FRAC_W;
  localparam int CFG_W   = 2;

  localparam logic [1:0] OP_WRITE_LEFT  = 2'd0;
  localparam logic [1:0] OP_WRITE_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  localparam logic [CFG_W-1:0] CFG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_W-1:0] CFG_COL_COUNT     = 2'd1;
  localparam logic [CFG_W-1:0] CFG_INNER_COUNT   = 2'd2;
  localparam logic [CFG_W-1:0] CFG_NEGATE_RESULT = 2'd3;

  localparam logic [CNT_W-1:0] DIM_RESET = CNT_W'(MAX_DIM);

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                    out_last;
  } out_item_t;

  typedef struct packed {
    logic              wr_left;
    logic              wr_right;
    logic              rd_en;
    logic              first;
    logic [ADDR_W-1:0] left_addr;
    logic [ADDR_W-1:0] right_addr;
    logic              emit;
    logic              negate;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } mmn_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } mmn_status_t;

  // highest index for a dimension register: zero acts as one, large values clamp
  function automatic logic [IDX_W-1:0] dim_last(input logic [CNT_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CNT_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - CNT_W'(1));
    end
    return r;
  endfunction

endpackage

>>> sv/mmn_ram.sv
// generic single write port ram with registered read
module mmn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/mmn_datapath.sv
// element stores, multiply-accumulate pipeline and result register
module mmn_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mmn_pkg::in_item_t   in_data,
  input  mmn_pkg::mmn_cmd_t   cmd,
  output mmn_pkg::mmn_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output mmn_pkg::out_item_t  out_data
);

  logic [mmn_pkg::ADDR_W-1:0]          waddr;
  logic [mmn_pkg::DATA_W-1:0]          left_q;
  logic [mmn_pkg::DATA_W-1:0]          right_q;
  logic                                rd_v1;
  logic                                first1;
  logic                                prod_v;
  logic                                first2;
  logic signed [mmn_pkg::PROD_W-1:0]   prod;
  logic signed [mmn_pkg::ACC_W-1:0]    acc;
  logic signed [mmn_pkg::TRUNC_W-1:0]  trunc;
  logic signed [mmn_pkg::TRUNC_W:0]    value;
  logic signed [mmn_pkg::DATA_W-1:0]   sat;

  assign waddr = {in_data.row_index, in_data.col_index};

  mmn_ram #(.WIDTH(mmn_pkg::DATA_W), .DEPTH(mmn_pkg::DEPTH)) u_left (
    .clk   (clk),
    .we    (cmd.wr_left),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .re    (cmd.rd_en),
    .raddr (cmd.left_addr),
    .rdata (left_q)
  );

  mmn_ram #(.WIDTH(mmn_pkg::DATA_W), .DEPTH(mmn_pkg::DEPTH)) u_right (
    .clk   (clk),
    .we    (cmd.wr_right),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .re    (cmd.rd_en),
    .raddr (cmd.right_addr),
    .rdata (right_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1  <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v1  <= cmd.rd_en;
      prod_v <= rd_v1;
    end
    first1 <= cmd.first;
    first2 <= first1;
    prod   <= $signed(left_q) * $signed(right_q);
    if (prod_v) begin
      if (first2) begin
        acc <= mmn_pkg::ACC_W'(prod);
      end else begin
        acc <= acc + mmn_pkg::ACC_W'(prod);
      end
    end
  end

  assign status.busy = rd_v1 | prod_v;

  // drop fraction bits, negate at full width, then saturate
  always_comb begin
    trunc = acc[mmn_pkg::ACC_W-1:mmn_pkg::FRAC_W];
    if (cmd.negate) begin
      value = -(mmn_pkg::TRUNC_W+1)'(trunc);
    end else begin
      value = (mmn_pkg::TRUNC_W+1)'(trunc);
    end
    if (value[mmn_pkg::TRUNC_W:mmn_pkg::DATA_W-1] == '0 ||
        value[mmn_pkg::TRUNC_W:mmn_pkg::DATA_W-1] == '1) begin
      sat = value[mmn_pkg::DATA_W-1:0];
    end else if (value[mmn_pkg::TRUNC_W]) begin
      sat = {1'b1, {(mmn_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(mmn_pkg::DATA_W-1){1'b1}}};
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_data.out_row   <= cmd.row;
      out_data.out_col   <= cmd.col;
      out_data.out_value <= sat;
      out_data.out_last  <= cmd.last;
    end
  end

endmodule

>>> sv/mmn_ctrl.sv
// configuration registers and sequencer over rows, columns and inner index
module mmn_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic                        cfg_valid,
  input  logic [mmn_pkg::CFG_W-1:0]   cfg_index,
  input  logic [mmn_pkg::CNT_W-1:0]   cfg_data,
  input  mmn_pkg::mmn_status_t        status,
  output mmn_pkg::mmn_cmd_t           cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [mmn_pkg::IDX_W-1:0]  r;
  logic [mmn_pkg::IDX_W-1:0]  r_next;
  logic [mmn_pkg::IDX_W-1:0]  c;
  logic [mmn_pkg::IDX_W-1:0]  c_next;
  logic [mmn_pkg::IDX_W-1:0]  k;
  logic [mmn_pkg::IDX_W-1:0]  k_next;
  logic [mmn_pkg::CNT_W-1:0]  row_count;
  logic [mmn_pkg::CNT_W-1:0]  col_count;
  logic [mmn_pkg::CNT_W-1:0]  inner_count;
  logic                       negate_result;
  logic [mmn_pkg::IDX_W-1:0]  r_last;
  logic [mmn_pkg::IDX_W-1:0]  c_last;
  logic [mmn_pkg::IDX_W-1:0]  k_last;
  logic                       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= mmn_pkg::DIM_RESET;
      col_count     <= mmn_pkg::DIM_RESET;
      inner_count   <= mmn_pkg::DIM_RESET;
      negate_result <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmn_pkg::CFG_ROW_COUNT:     row_count     <= cfg_data;
        mmn_pkg::CFG_COL_COUNT:     col_count     <= cfg_data;
        mmn_pkg::CFG_INNER_COUNT:   inner_count   <= cfg_data;
        mmn_pkg::CFG_NEGATE_RESULT: negate_result <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign r_last   = mmn_pkg::dim_last(row_count);
  assign c_last   = mmn_pkg::dim_last(col_count);
  assign k_last   = mmn_pkg::dim_last(inner_count);
  assign in_ready = (state == S_IDLE) && !rst;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    k_next     = k;

    cmd            = '0;
    cmd.left_addr  = {r, k};
    cmd.right_addr = {k, c};
    cmd.first      = (k == '0);
    cmd.negate     = negate_result;
    cmd.row        = r;
    cmd.col        = c;
    cmd.last       = (r == r_last) && (c == c_last);

    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (operation)
            mmn_pkg::OP_WRITE_LEFT:  cmd.wr_left  = 1'b1;
            mmn_pkg::OP_WRITE_RIGHT: cmd.wr_right = 1'b1;
            mmn_pkg::OP_COMPUTE: begin
              r_next     = '0;
              c_next     = '0;
              k_next     = '0;
              state_next = S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (k == k_last) begin
          state_next = S_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_DRAIN: begin
        // accumulator final once the pipeline has emptied
        if (!status.busy && status.out_free) begin
          cmd.emit = 1'b1;
          k_next   = '0;
          if (cmd.last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_ISSUE;
            if (c == c_last) begin
              c_next = '0;
              r_next = r + 1'b1;
            end else begin
              c_next = c + 1'b1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

endmodule

>>> sv/matrix_multiply_negate.sv
// top level of the dense matrix multiply with optional negation
// Write items (operation 0 or 1) store a Q16.16 element into the left or
// right 8x8 store. A compute item (operation 2) holds off input while the
// product is formed one element at a time in row-major order by one
// shared 32x32 multiplier fed from one read port per store. Each element
// passes through the read, product and accumulator registers, and waits
// until the output register is free before it is emitted. Sums are exact,
// truncated toward minus infinity to Q16.16, negated when negate_result
// is set, then saturated to 32 bits.
// Configuration may only be written while no compute is in progress.
module matrix_multiply_negate (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mmn_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mmn_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mmn_pkg::CFG_W-1:0] cfg_index,
  input  logic [mmn_pkg::CNT_W-1:0] cfg_data
);

  mmn_pkg::mmn_cmd_t    cmd;
  mmn_pkg::mmn_status_t status;

  assign cfg_ready = !rst;

  mmn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_data.operation),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  mmn_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
